/* rtl/min_tracking_stack_unit_assert.svh */
// ---------------------------------------------------------------------------
// min_tracking_stack_unit_assert.svh
// Assertion macros shared by the min tracking stack checker.
// ---------------------------------------------------------------------------
`ifndef MIN_TRACKING_STACK_UNIT_ASSERT_SVH
`define MIN_TRACKING_STACK_UNIT_ASSERT_SVH

// same-cycle implication, clocked on i_clk, held off during reset
`define MTS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: implication failed");

// next-cycle implication, clocked on i_clk, held off during reset
`define MTS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication failed");

`endif

/* rtl/mts_pkg.sv */
// ---------------------------------------------------------------------------
// mts_pkg
// Operation and status codes of the min tracking stack.
// ---------------------------------------------------------------------------
package mts_pkg;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    localparam int STATUS_W = 2;

endpackage

/* rtl/mts_ram.sv */
// ---------------------------------------------------------------------------
// mts_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module mts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/mts_ctrl.sv */
// ---------------------------------------------------------------------------
// mts_ctrl
// Sequencer of the min tracking stack: counts, cached minimum, memory
// requests and the result register.
// ---------------------------------------------------------------------------
module mts_ctrl #(
    parameter int DATA_WIDTH  = 32,
    parameter int STACK_DEPTH = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input word
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_operation,
    input  logic signed [DATA_WIDTH-1:0]     i_value,
    // result word
    output logic                             o_res_valid,
    input  logic                             i_res_ready,
    output logic signed [DATA_WIDTH-1:0]     o_min_value,
    output logic                             o_min_valid,
    output logic [$clog2(STACK_DEPTH+1)-1:0] o_fill_count,
    output logic [mts_pkg::STATUS_W-1:0]     o_status,
    // element memory
    output logic                             o_elem_we,
    output logic [$clog2(STACK_DEPTH)-1:0]   o_elem_waddr,
    output logic [DATA_WIDTH-1:0]            o_elem_wdata,
    output logic                             o_elem_re,
    output logic [$clog2(STACK_DEPTH)-1:0]   o_elem_raddr,
    input  logic [DATA_WIDTH-1:0]            i_elem_rdata,
    // minimum position memory
    output logic                             o_pos_we,
    output logic [$clog2(STACK_DEPTH)-1:0]   o_pos_waddr,
    output logic [$clog2(STACK_DEPTH)-1:0]   o_pos_wdata,
    output logic                             o_pos_re,
    output logic [$clog2(STACK_DEPTH)-1:0]   o_pos_raddr,
    input  logic [$clog2(STACK_DEPTH)-1:0]   i_pos_rdata
);

    import mts_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD_POS,
        S_RD_ELEM,
        S_EMIT
    } t_state;

    t_state                  r_state;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           r_mcount;
    logic [AW-1:0]           r_min_pos;
    logic signed [DATA_WIDTH-1:0] r_min_val;
    t_status                 r_status;

    logic                    r_m_valid;
    logic signed [DATA_WIDTH-1:0] r_m_min;
    logic                    r_m_mvalid;
    logic [CW-1:0]           r_m_count;
    t_status                 r_m_status;

    logic          accept;
    logic          is_push;
    logic          full;
    logic          empty;
    logic          record;
    logic [CW-1:0] popped;
    logic          drop;
    logic          reread;
    logic [AW-1:0] mcount_m2;
    logic          out_free;
    logic          held;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign is_push    = (i_operation == OP_PUSH);
    assign full       = (r_count == CW'(STACK_DEPTH));
    assign empty      = (r_count == '0);
    assign record     = (r_mcount == '0) || (i_value < r_min_val);
    assign popped     = r_count - CW'(1);
    assign drop       = (r_mcount != '0) && (r_min_pos == popped[AW-1:0]);
    // dropping a record that is not the last one exposes an older minimum
    assign reread     = drop && (r_mcount != CW'(1));
    assign mcount_m2  = r_mcount[AW-1:0] - AW'(2);
    assign out_free   = !r_m_valid || i_res_ready;
    assign held       = (r_count != '0) && (r_mcount != '0);

    assign o_elem_we    = accept && is_push && !full;
    assign o_elem_waddr = r_count[AW-1:0];
    assign o_elem_wdata = i_value;
    assign o_elem_re    = (r_state == S_RD_POS);
    assign o_elem_raddr = i_pos_rdata;

    assign o_pos_we    = accept && is_push && !full && record;
    assign o_pos_waddr = r_mcount[AW-1:0];
    assign o_pos_wdata = r_count[AW-1:0];
    assign o_pos_re    = accept && !is_push && !empty && reread;
    assign o_pos_raddr = mcount_m2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_mcount  <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if ((r_state == S_EMIT) && out_free) begin
                r_m_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (is_push) begin
                            r_state <= S_EMIT;
                            if (full) begin
                                r_status <= ST_FULL;
                            end else begin
                                r_status <= ST_DONE;
                                r_count  <= r_count + CW'(1);
                                if (record) begin
                                    r_mcount  <= r_mcount + CW'(1);
                                    r_min_pos <= r_count[AW-1:0];
                                    r_min_val <= i_value;
                                end
                            end
                        end else begin
                            if (empty) begin
                                r_state  <= S_EMIT;
                                r_status <= ST_EMPTY;
                            end else begin
                                r_status <= ST_DONE;
                                r_count  <= popped;
                                if (drop) begin
                                    r_mcount <= r_mcount - CW'(1);
                                end
                                r_state <= reread ? S_RD_POS : S_EMIT;
                            end
                        end
                    end
                end
                S_RD_POS: begin
                    // new top record is in; fetch the element it points at
                    r_min_pos <= i_pos_rdata;
                    r_state   <= S_RD_ELEM;
                end
                S_RD_ELEM: begin
                    r_min_val <= i_elem_rdata;
                    r_state   <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_m_min    <= held ? r_min_val : '0;
                        r_m_mvalid <= held;
                        r_m_count  <= r_count;
                        r_m_status <= r_status;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res_valid  = r_m_valid;
    assign o_min_value  = r_m_min;
    assign o_min_valid  = r_m_mvalid;
    assign o_fill_count = r_m_count;
    assign o_status     = r_m_status;

endmodule

/* rtl/min_tracking_stack_unit.sv */
// ---------------------------------------------------------------------------
// min_tracking_stack_unit
// Stack of signed words that reports its minimum after every push or pop.
//
// Channel   Dir  Fields (low bit up)
// s_axis    in   tdata: value; tuser: operation (0 push, 1 pop)
// m_axis    out  tdata: min_value, min_valid, fill_count, status
//
// Each word goes straight to the result step, except a pop that drops the
// current minimum record while an older one remains: it first reads the
// next minimum record from the position memory, then the element memory
// at that position. Reset clears the counts; memories need no clearing.
// A new word is taken while the previous result waits on m_axis; a stall
// there holds the block in its final step until the result moves.
// ---------------------------------------------------------------------------
module min_tracking_stack_unit #(
    parameter int DATA_WIDTH  = 32,
    parameter int STACK_DEPTH = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // value
    input  logic [((DATA_WIDTH+7)/8)*8-1:0]          i_s_axis_tdata,
    // operation
    input  logic [0:0]                               i_s_axis_tuser,
    output logic                                     o_m_axis_tvalid,
    input  logic                                     i_m_axis_tready,
    // min_value, min_valid, fill_count, status
    output logic [((DATA_WIDTH+$clog2(STACK_DEPTH+1)+3+7)/8)*8-1:0] o_m_axis_tdata
);

    import mts_pkg::*;

    localparam int AW     = $clog2(STACK_DEPTH);
    localparam int CW     = $clog2(STACK_DEPTH + 1);
    localparam int OUT_W  = DATA_WIDTH + 1 + CW + STATUS_W;
    localparam int OUT_BW = ((OUT_W + 7) / 8) * 8;

    logic signed [DATA_WIDTH-1:0] min_value;
    logic                         min_valid;
    logic [CW-1:0]                fill_count;
    logic [STATUS_W-1:0]          status;

    logic                  elem_we;
    logic [AW-1:0]         elem_waddr;
    logic [DATA_WIDTH-1:0] elem_wdata;
    logic                  elem_re;
    logic [AW-1:0]         elem_raddr;
    logic [DATA_WIDTH-1:0] elem_rdata;
    logic                  pos_we;
    logic [AW-1:0]         pos_waddr;
    logic [AW-1:0]         pos_wdata;
    logic                  pos_re;
    logic [AW-1:0]         pos_raddr;
    logic [AW-1:0]         pos_rdata;

    mts_ctrl #(
        .DATA_WIDTH  (DATA_WIDTH),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_s_axis_tvalid),
        .o_in_ready   (o_s_axis_tready),
        .i_operation  (i_s_axis_tuser[0]),
        .i_value      ($signed(i_s_axis_tdata[DATA_WIDTH-1:0])),
        .o_res_valid  (o_m_axis_tvalid),
        .i_res_ready  (i_m_axis_tready),
        .o_min_value  (min_value),
        .o_min_valid  (min_valid),
        .o_fill_count (fill_count),
        .o_status     (status),
        .o_elem_we    (elem_we),
        .o_elem_waddr (elem_waddr),
        .o_elem_wdata (elem_wdata),
        .o_elem_re    (elem_re),
        .o_elem_raddr (elem_raddr),
        .i_elem_rdata (elem_rdata),
        .o_pos_we     (pos_we),
        .o_pos_waddr  (pos_waddr),
        .o_pos_wdata  (pos_wdata),
        .o_pos_re     (pos_re),
        .o_pos_raddr  (pos_raddr),
        .i_pos_rdata  (pos_rdata)
    );

    mts_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (STACK_DEPTH)
    ) u_elem_ram (
        .i_clk   (i_clk),
        .i_we    (elem_we),
        .i_waddr (elem_waddr),
        .i_wdata (elem_wdata),
        .i_re    (elem_re),
        .i_raddr (elem_raddr),
        .o_rdata (elem_rdata)
    );

    mts_ram #(
        .WIDTH (AW),
        .DEPTH (STACK_DEPTH)
    ) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_waddr (pos_waddr),
        .i_wdata (pos_wdata),
        .i_re    (pos_re),
        .i_raddr (pos_raddr),
        .o_rdata (pos_rdata)
    );

    assign o_m_axis_tdata = {{(OUT_BW - OUT_W){1'b0}}, status, fill_count, min_valid,
                             min_value};

endmodule

/* rtl/mts_checker.sv */
// ---------------------------------------------------------------------------
// mts_checker
// Port-level checks of the min tracking stack, bound to the top level.
// ---------------------------------------------------------------------------
`include "min_tracking_stack_unit_assert.svh"

module mts_checker #(
    parameter int DATA_WIDTH  = 32,
    parameter int STACK_DEPTH = 64
) (
    input logic                                     i_clk,
    input logic                                     i_rst_n,
    input logic                                     i_s_axis_tvalid,
    input logic                                     o_s_axis_tready,
    // value
    input logic [((DATA_WIDTH+7)/8)*8-1:0]          i_s_axis_tdata,
    // operation
    input logic [0:0]                               i_s_axis_tuser,
    input logic                                     o_m_axis_tvalid,
    input logic                                     i_m_axis_tready,
    // min_value, min_valid, fill_count, status
    input logic [((DATA_WIDTH+$clog2(STACK_DEPTH+1)+3+7)/8)*8-1:0] o_m_axis_tdata
);

    import mts_pkg::*;

    localparam int CW    = $clog2(STACK_DEPTH + 1);
    localparam int VB    = DATA_WIDTH;
    localparam int CB    = DATA_WIDTH + 1;
    localparam int SB    = DATA_WIDTH + 1 + CW;

    logic [DATA_WIDTH-1:0] min_value;
    logic                  min_valid;
    logic [CW-1:0]         fill_count;
    logic [STATUS_W-1:0]   status;

    assign min_value  = o_m_axis_tdata[DATA_WIDTH-1:0];
    assign min_valid  = o_m_axis_tdata[VB];
    assign fill_count = o_m_axis_tdata[CB+CW-1:CB];
    assign status     = o_m_axis_tdata[SB+STATUS_W-1:SB];

    // a waiting input word holds
    `MTS_ASSERT_NEXT(a_in_hold, i_s_axis_tvalid && !o_s_axis_tready,
                     i_s_axis_tvalid && $stable(i_s_axis_tdata) && $stable(i_s_axis_tuser))
    // a stalled result holds
    `MTS_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready,
                     o_m_axis_tvalid && $stable(o_m_axis_tdata))
    // a minimum exists exactly when the stack holds something
    `MTS_ASSERT_IMPL(a_valid_count, o_m_axis_tvalid,
                     (min_valid == (fill_count != '0)) && (fill_count <= CW'(STACK_DEPTH)))
    // a refused push only happens on a full stack
    `MTS_ASSERT_IMPL(a_full_refuse, o_m_axis_tvalid && (status == ST_FULL),
                     fill_count == CW'(STACK_DEPTH))
    // a refused pop only happens on an empty stack, which reports zero
    `MTS_ASSERT_IMPL(a_empty_refuse, o_m_axis_tvalid && (status == ST_EMPTY),
                     (fill_count == '0) && (min_value == '0))

endmodule

bind min_tracking_stack_unit mts_checker #(
    .DATA_WIDTH  (DATA_WIDTH),
    .STACK_DEPTH (STACK_DEPTH)
) u_mts_checker (.*);
